// ===== hdl/spmf_pkg.sv =====
// Package for the strict-priority multilevel queue.
// Holds item types, status and op codes and the shared constants.
// No dependencies.
package spmf_pkg;

    localparam int DATA_W      = 32;
    localparam int FILL_W      = 5;
    localparam int PRIO_W      = 3;
    localparam int LEVELS_DEF  = 4;
    localparam int DEPTH_DEF   = 16;
    localparam int CMDQ_DEPTH  = 4;
    localparam int OUTQ_DEPTH  = 4;

    localparam logic       CMD_ENQ      = 1'b0;
    localparam logic       CMD_DEQ      = 1'b1;
    localparam logic       REG_CAPACITY = 1'b0;
    localparam logic       REG_LEVELS   = 1'b1;
    localparam logic [4:0] CAP_RESET    = 5'd16;
    localparam logic [2:0] LEV_RESET    = 3'd4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_BAD_PRIO = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef struct packed {
        logic                     cmd;
        logic signed [DATA_W-1:0] value;
        logic [PRIO_W-1:0]        priority_req;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic [1:0]               status;
        logic [FILL_W-1:0]        occupancy;
        logic                     is_full;
        logic                     is_empty;
    } t_result;

    // Classified operation handed from the front to the back
    typedef struct packed {
        t_op               op;
        t_status           status;
        logic [FILL_W-1:0] occupancy;
        logic              is_full;
        logic              is_empty;
    } t_meta;

endpackage

// ===== hdl/spmf_front.sv =====
// Front end: classifies each item and keeps the ring pointers and fill counts.
// Emits the store address and the result flags; depends on spmf_pkg.
module spmf_front
    import spmf_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF,
    parameter int DEPTH  = DEPTH_DEF,
    parameter int AW     = $clog2(LEVELS_DEF * DEPTH_DEF)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_in_item          i_item,
    input  logic [FILL_W-1:0] i_capacity,
    input  logic [2:0]        i_levels_in_use,
    output t_meta             o_meta,
    output logic [AW-1:0]     o_addr,
    output logic [DATA_W-1:0] o_wdata
);

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PW = $clog2(DEPTH);

    logic [PW-1:0]     r_head [LEVELS];
    logic [PW-1:0]     r_tail [LEVELS];
    logic [FILL_W-1:0] r_level_fill [LEVELS];
    logic [FILL_W-1:0] r_total_fill;
    logic [PW-1:0]     n_head [LEVELS];
    logic [PW-1:0]     n_tail [LEVELS];
    logic [FILL_W-1:0] n_level_fill [LEVELS];
    logic [FILL_W-1:0] n_total_fill;

    logic [FILL_W-1:0] cap_eff;
    logic [4:0]        lev_eff;
    logic [LW-1:0]     enq_level;
    logic [LW-1:0]     deq_level;
    logic              found;
    logic              enq_ok;

    always_comb begin
        // capacity above DEPTH saturates at DEPTH
        if (11'(i_capacity) > 11'(DEPTH)) begin
            cap_eff = FILL_W'(DEPTH);
        end else begin
            cap_eff = i_capacity;
        end
        if (5'(i_levels_in_use) > 5'(LEVELS)) begin
            lev_eff = 5'(LEVELS);
        end else begin
            lev_eff = 5'(i_levels_in_use);
        end
    end

    // lowest-numbered non-empty level wins
    always_comb begin
        found     = 1'b0;
        deq_level = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_level_fill[l] != '0) begin
                found     = 1'b1;
                deq_level = LW'(l);
            end
        end
    end

    always_comb begin
        enq_level    = LW'(i_item.priority_req - PRIO_W'(1));
        n_head       = r_head;
        n_tail       = r_tail;
        n_level_fill = r_level_fill;
        n_total_fill = r_total_fill;
        o_meta.op     = OP_NONE;
        o_meta.status = ST_OK;
        o_addr        = '0;
        o_wdata       = i_item.value;
        enq_ok        = 1'b0;
        if (i_item.cmd == CMD_ENQ) begin
            if (r_total_fill >= cap_eff) begin
                o_meta.status = ST_FULL;
            end else if (i_item.priority_req == '0 ||
                         5'(i_item.priority_req) > lev_eff) begin
                o_meta.status = ST_BAD_PRIO;
            end else begin
                enq_ok    = 1'b1;
                o_meta.op = OP_WRITE;
                o_addr    = AW'(enq_level) * AW'(DEPTH) + AW'(r_tail[enq_level]);
                n_tail[enq_level] = (r_tail[enq_level] == PW'(DEPTH - 1)) ?
                                    '0 : r_tail[enq_level] + PW'(1);
                n_level_fill[enq_level] = r_level_fill[enq_level] + FILL_W'(1);
                n_total_fill = r_total_fill + FILL_W'(1);
            end
        end else begin
            if (!found) begin
                o_meta.status = ST_EMPTY;
            end else begin
                o_meta.op = OP_READ;
                o_addr    = AW'(deq_level) * AW'(DEPTH) + AW'(r_head[deq_level]);
                n_head[deq_level] = (r_head[deq_level] == PW'(DEPTH - 1)) ?
                                    '0 : r_head[deq_level] + PW'(1);
                n_level_fill[deq_level] = r_level_fill[deq_level] - FILL_W'(1);
                n_total_fill = r_total_fill - FILL_W'(1);
            end
        end
        o_meta.occupancy = n_total_fill;
        o_meta.is_full   = (n_total_fill >= cap_eff);
        o_meta.is_empty  = (n_total_fill == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l]       <= '0;
                r_tail[l]       <= '0;
                r_level_fill[l] <= '0;
            end
            r_total_fill <= '0;
        end else if (i_accept) begin
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_level_fill <= n_level_fill;
            r_total_fill <= n_total_fill;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        11'(r_total_fill) <= 11'(DEPTH))
        else $error("total fill above ring depth");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && enq_ok |=> r_total_fill == $past(r_total_fill) + FILL_W'(1))
        else $error("accepted enqueue did not raise the fill");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.cmd == CMD_DEQ && r_total_fill == '0 |->
        o_meta.status == ST_EMPTY)
        else $error("dequeue on empty queue not rejected");

endmodule

// ===== hdl/spmf_cmd_q.sv =====
// Short queue of classified operations between front and back.
// Register file of CMDQ_DEPTH entries; depends on spmf_pkg.
module spmf_cmd_q
    import spmf_pkg::*;
#(
    parameter int AW = $clog2(LEVELS_DEF * DEPTH_DEF)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_meta             i_meta,
    input  logic [AW-1:0]     i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output t_meta             o_meta,
    output logic [AW-1:0]     o_addr,
    output logic [DATA_W-1:0] o_wdata
);

    localparam int QW = $clog2(CMDQ_DEPTH);

    t_meta             r_meta  [CMDQ_DEPTH];
    logic [AW-1:0]     r_addr  [CMDQ_DEPTH];
    logic [DATA_W-1:0] r_wdata [CMDQ_DEPTH];
    logic [QW-1:0]     r_wr_ptr;
    logic [QW-1:0]     r_rd_ptr;
    logic [QW:0]       r_count;

    assign o_full  = (r_count == (QW + 1)'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_meta  = r_meta[r_rd_ptr];
    assign o_addr  = r_addr[r_rd_ptr];
    assign o_wdata = r_wdata[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_meta[r_wr_ptr]  <= i_meta;
            r_addr[r_wr_ptr]  <= i_addr;
            r_wdata[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QW'(1);
            end
            r_count <= r_count + (QW + 1)'(i_push) - (QW + 1)'(i_pop);
        end
    end

endmodule

// ===== hdl/spmf_back.sv =====
// Back end: shared entry store, registered read and the result queue.
// Carries out the operations taken from the command queue; depends on spmf_pkg.
module spmf_back
    import spmf_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF,
    parameter int DEPTH  = DEPTH_DEF,
    parameter int AW     = $clog2(LEVELS_DEF * DEPTH_DEF)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cq_empty,
    input  t_meta             i_meta,
    input  logic [AW-1:0]     i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic              o_cq_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output t_result           o_result
);

    localparam int ENTRIES = LEVELS * DEPTH;
    localparam int OW      = $clog2(OUTQ_DEPTH);

    logic [DATA_W-1:0] r_mem [ENTRIES];
    logic [DATA_W-1:0] r_rdata;
    t_meta             r_meta;
    logic              r_inflight;

    t_result           r_oq [OUTQ_DEPTH];
    logic [OW-1:0]     r_oq_wr;
    logic [OW-1:0]     r_oq_rd;
    logic [OW:0]       r_oq_count;

    t_result           res;
    logic              oq_pop;

    // in-flight read counts against the result queue's room
    assign o_cq_pop = !i_cq_empty &&
                      ((OW + 1)'(r_oq_count) + (OW + 1)'(r_inflight) <
                       (OW + 1)'(OUTQ_DEPTH));
    assign oq_pop   = i_pop && !o_empty;
    assign o_empty  = (r_oq_count == '0);
    assign o_result = r_oq[r_oq_rd];

    always_ff @(posedge i_clk) begin
        if (o_cq_pop) begin
            if (i_meta.op == OP_WRITE) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
            r_meta  <= i_meta;
        end
    end

    always_comb begin
        res.data_out  = (r_meta.op == OP_READ) ? r_rdata : '0;
        res.status    = r_meta.status;
        res.occupancy = r_meta.occupancy;
        res.is_full   = r_meta.is_full;
        res.is_empty  = r_meta.is_empty;
    end

    always_ff @(posedge i_clk) begin
        if (r_inflight) begin
            r_oq[r_oq_wr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 1'b0;
            r_oq_wr    <= '0;
            r_oq_rd    <= '0;
            r_oq_count <= '0;
        end else begin
            r_inflight <= o_cq_pop;
            if (r_inflight) begin
                r_oq_wr <= r_oq_wr + OW'(1);
            end
            if (oq_pop) begin
                r_oq_rd <= r_oq_rd + OW'(1);
            end
            r_oq_count <= r_oq_count + (OW + 1)'(r_inflight) - (OW + 1)'(oq_pop);
        end
    end

    a_oq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (OW + 1)'(r_oq_count) + (OW + 1)'(r_inflight) <= (OW + 1)'(OUTQ_DEPTH))
        else $error("result queue overcommitted");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_result.status != ST_OK |-> o_result.data_out == '0)
        else $error("rejected item carries data");

    a_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cq_pop |=> r_inflight)
        else $error("popped operation lost");

endmodule

// ===== hdl/strict_priority_multi_fifo.sv =====
// Strict-priority multilevel queue: one ring per level in a shared store.
// Throughput: one item per cycle while the command queue is not full; the front
// updates pointers for each accepted item and the store takes one write or one
// registered read per cycle.
// Reset (synchronous, active low) empties all levels and loads capacity 16,
// levels in use 4; the store itself is not cleared.
module strict_priority_multi_fifo
    import spmf_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF,
    parameter int DEPTH  = DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_item,
    output logic        empty,
    input  logic        pop,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(LEVELS * DEPTH);

    logic [FILL_W-1:0] r_capacity;
    logic [2:0]        r_levels_in_use;

    logic              accept;
    t_meta             f_meta;
    logic [AW-1:0]     f_addr;
    logic [DATA_W-1:0] f_wdata;
    t_meta             q_meta;
    logic [AW-1:0]     q_addr;
    logic [DATA_W-1:0] q_wdata;
    logic              q_empty;
    logic              q_pop;

    assign pready = 1'b1;
    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity      <= CAP_RESET;
            r_levels_in_use <= LEV_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_CAPACITY: r_capacity      <= pwdata[FILL_W-1:0];
                REG_LEVELS:   r_levels_in_use <= pwdata[2:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CAPACITY: prdata = 32'(r_capacity);
            REG_LEVELS:   prdata = 32'(r_levels_in_use);
            default:      prdata = '0;
        endcase
    end

    spmf_front #(
        .LEVELS (LEVELS),
        .DEPTH  (DEPTH),
        .AW     (AW)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_item          (i_item),
        .i_capacity      (r_capacity),
        .i_levels_in_use (r_levels_in_use),
        .o_meta          (f_meta),
        .o_addr          (f_addr),
        .o_wdata         (f_wdata)
    );

    spmf_cmd_q #(
        .AW (AW)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_meta  (f_meta),
        .i_addr  (f_addr),
        .i_wdata (f_wdata),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_meta  (q_meta),
        .o_addr  (q_addr),
        .o_wdata (q_wdata)
    );

    spmf_back #(
        .LEVELS (LEVELS),
        .DEPTH  (DEPTH),
        .AW     (AW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cq_empty (q_empty),
        .i_meta     (q_meta),
        .i_addr     (q_addr),
        .i_wdata    (q_wdata),
        .o_cq_pop   (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

endmodule

// ===== verif/testbench.sv =====
// Testbench for strict_priority_multi_fifo: directed table, then random phases of items
// under varying capacity and level settings, checked against fixed rows or a behavioural model.
// Depends on spmf_pkg and the top-level RTL only.
module testbench;
    import spmf_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_item    i_item;
    logic        empty;
    logic        pop;
    t_result     o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    strict_priority_multi_fifo u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    localparam int TOTAL_ITEMS = 1950;

    // Queue model state
    logic [DATA_W-1:0] stored_words [LEVELS_DEF][DEPTH_DEF];
    int                ring_head    [LEVELS_DEF];
    int                ring_tail    [LEVELS_DEF];
    int                ring_count   [LEVELS_DEF];
    int                stored_total;
    logic [4:0]        cap_reg;
    logic [2:0]        lev_reg;

    t_result pending_outcomes [$];
    int      fault_count;
    int      items_sent;

    typedef struct {
        bit         is_cfg;
        logic       reg_sel;
        logic [4:0] reg_val;
        t_in_item   item;
        bit         fixed;
        t_result    res;
    } t_row;

    t_row dir_rows [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (400000) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int eff_cap();
        return (cap_reg > DEPTH_DEF) ? DEPTH_DEF : int'(cap_reg);
    endfunction

    function automatic int eff_levels();
        return (lev_reg > LEVELS_DEF) ? LEVELS_DEF : int'(lev_reg);
    endfunction

    function automatic t_result next_outcome(t_in_item it);
        t_result r;
        int      l;
        bit      hit;
        r = '0;
        r.status = ST_OK;
        hit = 1'b0;
        if (it.cmd == CMD_ENQ) begin
            if (stored_total >= eff_cap()) begin
                r.status = ST_FULL;
            end else if (it.priority_req < 1 || it.priority_req > eff_levels()) begin
                r.status = ST_BAD_PRIO;
            end else begin
                l = it.priority_req - 1;
                stored_words[l][ring_tail[l]] = it.value;
                ring_tail[l] = (ring_tail[l] == DEPTH_DEF - 1) ? 0 : ring_tail[l] + 1;
                ring_count[l]++;
                stored_total++;
            end
        end else begin
            for (l = 0; l < LEVELS_DEF && !hit; l++) begin
                if (ring_count[l] != 0) begin
                    hit = 1'b1;
                    r.data_out = stored_words[l][ring_head[l]];
                    ring_head[l] = (ring_head[l] == DEPTH_DEF - 1) ? 0 : ring_head[l] + 1;
                    ring_count[l]--;
                    stored_total--;
                end
            end
            if (!hit) r.status = ST_EMPTY;
        end
        r.occupancy = FILL_W'(stored_total);
        r.is_full   = (stored_total >= eff_cap());
        r.is_empty  = (stored_total == 0);
        return r;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("mismatch: %s", msg);
    endtask

    // Result side: compare each popped item with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_outcomes.size() == 0) begin
                note_fault($sformatf("unexpected result data=%h status=%0d occ=%0d",
                                     o_result.data_out, o_result.status, o_result.occupancy));
            end else begin
                want = pending_outcomes.pop_front();
                if (o_result.data_out !== want.data_out || o_result.status !== want.status ||
                    o_result.occupancy !== want.occupancy ||
                    o_result.is_full !== want.is_full || o_result.is_empty !== want.is_empty)
                    note_fault($sformatf(
                        "exp data=%h st=%0d occ=%0d f=%b e=%b, got data=%h st=%0d occ=%0d f=%b e=%b",
                        want.data_out, want.status, want.occupancy, want.is_full,
                        want.is_empty, o_result.data_out, o_result.status,
                        o_result.occupancy, o_result.is_full, o_result.is_empty));
            end
        end
    end

    // Receiver: pop pattern switching between free-running, random and long stalls
    initial begin : receiver
        int mode;
        int span;
        int k;
        pop = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 60);
            for (k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= $urandom_range(0, 1);
                    default: pop <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input t_in_item it, input bit fixed, input t_result fixed_res);
        t_result pred;
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        pred = next_outcome(it);
        pending_outcomes.push_back(fixed ? fixed_res : pred);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Block must be idle before a register write
    task automatic settle();
        push <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic sel, input logic [4:0] val);
        logic [31:0] readback;
        readback = (sel == REG_CAPACITY) ? {27'd0, val} : {29'd0, val[2:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= readback;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (sel == REG_CAPACITY) cap_reg = val;
        else lev_reg = val[2:0];
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== readback)
            note_fault($sformatf("register %0d read %h, exp %h", sel, prdata, readback));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // return to idle before the next transfer
        @(negedge i_clk);
    endtask

    function automatic t_row row_item(logic cmd, logic [31:0] val, logic [2:0] prio);
        t_row r;
        r = '{default: '0};
        r.item.cmd = cmd;
        r.item.value = val;
        r.item.priority_req = prio;
        return r;
    endfunction

    function automatic t_row row_fixed(logic cmd, logic [31:0] val, logic [2:0] prio,
                                       logic [31:0] d, t_status st, int occ, bit f, bit e);
        t_row r;
        r = row_item(cmd, val, prio);
        r.fixed = 1'b1;
        r.res.data_out = d;
        r.res.status = st;
        r.res.occupancy = FILL_W'(occ);
        r.res.is_full = f;
        r.res.is_empty = e;
        return r;
    endfunction

    function automatic t_row row_reg(logic sel, logic [4:0] val);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    initial begin : stimulus
        t_in_item it;
        t_row     row;
        int       i;
        int       phase_len;
        int       enq_pct;
        int       burst_left;
        int       lev;
        bit       no_gaps;

        i_rst_n = 1'b0;
        push    = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        fault_count  = 0;
        items_sent   = 0;
        stored_total = 0;
        cap_reg = CAP_RESET;
        lev_reg = LEV_RESET;
        for (i = 0; i < LEVELS_DEF; i++) begin
            ring_head[i]  = 0;
            ring_tail[i]  = 0;
            ring_count[i] = 0;
        end

        // Directed: empty and bad-priority rejects, extremes, priority order
        dir_rows.push_back(row_fixed(CMD_DEQ, 32'd0, 3'd1, 32'd0, ST_EMPTY, 0, 0, 1));
        dir_rows.push_back(row_fixed(CMD_ENQ, 32'd5, 3'd0, 32'd0, ST_BAD_PRIO, 0, 0, 1));
        dir_rows.push_back(row_fixed(CMD_ENQ, 32'd5, 3'd5, 32'd0, ST_BAD_PRIO, 0, 0, 1));
        dir_rows.push_back(row_fixed(CMD_ENQ, 32'd5, 3'd7, 32'd0, ST_BAD_PRIO, 0, 0, 1));
        dir_rows.push_back(row_fixed(CMD_ENQ, 32'h8000_0000, 3'd4, 32'd0, ST_OK, 1, 0, 0));
        dir_rows.push_back(row_fixed(CMD_ENQ, 32'h7FFF_FFFF, 3'd1, 32'd0, ST_OK, 2, 0, 0));
        dir_rows.push_back(row_fixed(CMD_ENQ, 32'hFFFF_FFFF, 3'd2, 32'd0, ST_OK, 3, 0, 0));
        dir_rows.push_back(row_fixed(CMD_ENQ, 32'd0, 3'd3, 32'd0, ST_OK, 4, 0, 0));
        dir_rows.push_back(row_fixed(CMD_DEQ, 32'hFFFF_FFFF, 3'd7, 32'h7FFF_FFFF, ST_OK, 3, 0, 0));
        dir_rows.push_back(row_fixed(CMD_DEQ, 32'd0, 3'd0, 32'hFFFF_FFFF, ST_OK, 2, 0, 0));
        dir_rows.push_back(row_fixed(CMD_DEQ, 32'd0, 3'd0, 32'd0, ST_OK, 1, 0, 0));
        dir_rows.push_back(row_fixed(CMD_DEQ, 32'd0, 3'd0, 32'h8000_0000, ST_OK, 0, 0, 1));
        dir_rows.push_back(row_fixed(CMD_DEQ, 32'd0, 3'd0, 32'd0, ST_EMPTY, 0, 0, 1));
        // full beats bad priority
        dir_rows.push_back(row_reg(REG_CAPACITY, 5'd1));
        dir_rows.push_back(row_fixed(CMD_ENQ, 32'h0000_1234, 3'd2, 32'd0, ST_OK, 1, 1, 0));
        dir_rows.push_back(row_fixed(CMD_ENQ, 32'd9, 3'd0, 32'd0, ST_FULL, 1, 1, 0));
        dir_rows.push_back(row_fixed(CMD_DEQ, 32'd0, 3'd0, 32'h0000_1234, ST_OK, 0, 0, 1));
        // zero capacity: full and empty together
        dir_rows.push_back(row_reg(REG_CAPACITY, 5'd0));
        dir_rows.push_back(row_fixed(CMD_ENQ, 32'd1, 3'd1, 32'd0, ST_FULL, 0, 1, 1));
        // capacity above depth, then zero levels
        dir_rows.push_back(row_reg(REG_CAPACITY, 5'd31));
        dir_rows.push_back(row_reg(REG_LEVELS, 5'd0));
        dir_rows.push_back(row_fixed(CMD_ENQ, 32'd1, 3'd1, 32'd0, ST_BAD_PRIO, 0, 0, 1));
        // levels above the built-in count, then lowered: old values still drain
        dir_rows.push_back(row_reg(REG_LEVELS, 5'd7));
        dir_rows.push_back(row_item(CMD_ENQ, 32'hA5A5_A5A5, 3'd4));
        dir_rows.push_back(row_reg(REG_LEVELS, 5'd1));
        dir_rows.push_back(row_item(CMD_ENQ, 32'h5A5A_5A5A, 3'd2));
        dir_rows.push_back(row_item(CMD_DEQ, 32'd0, 3'd0));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.is_cfg) begin
                settle();
                write_reg(row.reg_sel, row.reg_val);
            end else begin
                send_item(row.item, row.fixed, row.res);
            end
        end

        // Random phases: new settings, then a run biased to fill, drain or balance
        while (items_sent < TOTAL_ITEMS) begin
            settle();
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0:       write_reg(REG_CAPACITY, 5'd0);
                    1:       write_reg(REG_CAPACITY, 5'd1);
                    2:       write_reg(REG_CAPACITY, 5'd16);
                    3:       write_reg(REG_CAPACITY, 5'($urandom_range(17, 31)));
                    default: write_reg(REG_CAPACITY, 5'($urandom_range(2, 15)));
                endcase
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0:       write_reg(REG_LEVELS, 5'd0);
                    1:       write_reg(REG_LEVELS, 5'($urandom_range(5, 7)));
                    2:       write_reg(REG_LEVELS, 5'd1);
                    3:       write_reg(REG_LEVELS, 5'd4);
                    default: write_reg(REG_LEVELS, 5'($urandom_range(1, 4)));
                endcase
            end
            case ($urandom_range(0, 2))
                0:       enq_pct = 75;
                1:       enq_pct = 25;
                default: enq_pct = 50;
            endcase
            no_gaps    = ($urandom_range(0, 3) == 0);
            phase_len  = $urandom_range(40, 90);
            burst_left = $urandom_range(1, 20);
            for (i = 0; i < phase_len && items_sent < TOTAL_ITEMS; i++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                    if (!no_gaps) begin
                        push <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(negedge i_clk);
                    end
                end
                burst_left--;
                it.cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
                case ($urandom_range(0, 15))
                    0:       it.value = 32'h8000_0000;
                    1:       it.value = 32'h7FFF_FFFF;
                    2:       it.value = 32'd0;
                    3:       it.value = 32'hFFFF_FFFF;
                    default: it.value = $urandom;
                endcase
                lev = eff_levels();
                if (lev > 0 && $urandom_range(0, 99) < 88)
                    it.priority_req = 3'($urandom_range(1, lev));
                else
                    it.priority_req = 3'($urandom_range(0, 7));
                send_item(it, 1'b0, '0);
            end
        end

        push <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== strict_priority_multi_fifo.f =====
hdl/spmf_pkg.sv
hdl/spmf_front.sv
hdl/spmf_cmd_q.sv
hdl/spmf_back.sv
hdl/strict_priority_multi_fifo.sv
verif/testbench.sv
